### rtl/asrch_pkg.sv
`timescale 1ns / 1ps
// Shared constants and action codes for the array search engine.
// No dependencies.
package asrch_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int ACT_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int POS_W   = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LINEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BINARY = 2'd2;

endpackage

### rtl/asrch_mem.sv
`timescale 1ns / 1ps
// Element store: one write port, one read port with registered read data.
// Depends on asrch_pkg.
module asrch_mem #(
  parameter int DEPTH = asrch_pkg::DEPTH_DEF,
  parameter int AW    = 4
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic signed [asrch_pkg::VALUE_W-1:0] wr_data,
  input  logic [AW-1:0]                       rd_addr,
  output logic signed [asrch_pkg::VALUE_W-1:0] rd_data
);
  import asrch_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/array_search_engine.sv
`timescale 1ns / 1ps
// Array search engine top level: control sequencer and stream ports.
// Depends on asrch_pkg and asrch_mem.
//
// A load returns nothing. A linear search reads the store one element per
// cycle from the top valid entry down; a binary search probes one element per
// cycle. The single read port of the element store, with its registered read
// data, paces both searches. One item is in work at a time; the next item is
// taken while a result still waits in the output register. The user must
// write element_count only while idle; the block itself does not enforce
// this. Values above DEPTH search DEPTH entries. Loads to a slot at or above
// DEPTH and items with an unknown action are dropped.
module array_search_engine #(
  parameter int DEPTH = asrch_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration: element_count
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [asrch_pkg::COUNT_W-1:0]        cfg_data,
  // input items
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [3:0] slot, [35:4] value, [39:36] zero
  input  logic [asrch_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] action
  input  logic [asrch_pkg::ACT_W-1:0]          in_tuser,
  // results
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] found, [5:1] position, [7:6] zero
  output logic [asrch_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import asrch_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int MW0 = (AW + 1 > CW) ? AW + 1 : CW;
  localparam int MW1 = (MW0 > COUNT_W) ? MW0 : COUNT_W;
  localparam int MW  = (MW1 > SLOT_W) ? MW1 : SLOT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIN,
    S_BIN,
    S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [AW-1:0]             cur_r, cur_nxt;
  logic [CW-1:0]             lo_r, lo_nxt;
  logic [CW-1:0]             hi_r, hi_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic                      res_found_r, res_found_nxt;
  logic [POS_W-1:0]          res_pos_r, res_pos_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]        count_r;

  logic [ACT_W-1:0]          in_action;
  logic [SLOT_W-1:0]         in_slot;
  logic signed [VALUE_W-1:0] in_value;
  logic                      in_xfer;
  logic [MW-1:0]             slot_x;
  logic                      slot_ok;
  logic [MW-1:0]             cnt_x;
  logic [MW-1:0]             vcnt_x;
  logic [CW-1:0]             vcnt;
  logic signed [VALUE_W-1:0] rd_data;
  logic                      key_eq;
  logic                      key_lt;
  logic [MW-1:0]             hit_pos;

  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [CW:0] sum;
    sum = (CW + 1)'(lo) + (CW + 1)'(hi) - (CW + 1)'(1);
    return sum[AW:1];
  endfunction

  assign in_action = in_tuser;
  assign in_slot   = in_tdata[SLOT_W-1:0];
  assign in_value  = in_tdata[SLOT_W+VALUE_W-1:SLOT_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign slot_x  = MW'(in_slot);
  assign slot_ok = (slot_x < MW'(DEPTH));

  assign cnt_x  = MW'(count_r);
  assign vcnt_x = (cnt_x > MW'(DEPTH)) ? MW'(DEPTH) : cnt_x;
  assign vcnt   = vcnt_x[CW-1:0];

  assign key_eq  = (rd_data == key_r);
  assign key_lt  = (key_r < rd_data);
  assign hit_pos = MW'(cur_r) + MW'(1);

  asrch_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (in_xfer && (in_action == ACT_LOAD) && slot_ok),
    .wr_addr (slot_x[AW-1:0]),
    .wr_data (in_value),
    .rd_addr (cur_nxt),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          key_nxt = in_value;
          if (in_action == ACT_LINEAR) begin
            if (vcnt == '0) begin
              res_found_nxt = 1'b0;
              res_pos_nxt   = '0;
              state_nxt     = S_DONE;
            end else begin
              cur_nxt   = AW'(vcnt - CW'(1));
              state_nxt = S_LIN;
            end
          end else if (in_action == ACT_BINARY) begin
            lo_nxt = '0;
            hi_nxt = vcnt;
            if (vcnt == '0) begin
              res_found_nxt = 1'b0;
              res_pos_nxt   = '0;
              state_nxt     = S_DONE;
            end else begin
              cur_nxt   = mid_of('0, vcnt);
              state_nxt = S_BIN;
            end
          end
        end
      end
      S_LIN: begin
        if (key_eq) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = hit_pos[POS_W-1:0];
          state_nxt     = S_DONE;
        end else if (cur_r == '0) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_DONE;
        end else begin
          cur_nxt = cur_r - AW'(1);
        end
      end
      S_BIN: begin
        if (key_eq) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = hit_pos[POS_W-1:0];
          state_nxt     = S_DONE;
        end else begin
          if (key_lt) begin
            hi_nxt = CW'(cur_r);
          end else begin
            lo_nxt = CW'(cur_r) + CW'(1);
          end
          if (lo_nxt < hi_nxt) begin
            cur_nxt = mid_of(lo_nxt, hi_nxt);
          end else begin
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r       <= cur_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_pos_r, out_found_r});

endmodule
